>>> sv/pee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_pkg
// Shared widths, character codes, status codes and control types for the
// postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

   localparam int DATA_W      = 32;
   localparam int SYM_W       = 8;
   localparam int DEPTH_W     = 7;
   localparam int STATUS_W    = 3;
   localparam int STACK_DEPTH = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int STEP_W      = $clog2(DATA_W + 1);

   localparam logic [SYM_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
   localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [SYM_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [SYM_W-1:0] CH_STAR  = 8'h2a;
   localparam logic [SYM_W-1:0] CH_SLASH = 8'h2f;
   localparam logic [SYM_W-1:0] CH_CARET = 8'h5e;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_IGNORED   = 3'd1,
      ST_UNDERFLOW = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_DIVZERO   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_POW
   } alu_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_EXEC,
      S_RESPOND
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       load;
      logic       push;
      logic       rd_below;
      logic       alu_start;
      logic       commit;
      logic       set_status;
      status_type status;
      logic       respond;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_digit;
      logic is_op;
      logic stack_full;
      logic stack_short;
      logic div_zero;
      logic alu_busy;
      logic out_free;
   } stat_type;

endpackage

>>> sv/pee_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_req_if
// Input channel: one symbol per transaction with its clear flag.
// ----------------------------------------------------------------------------
interface pee_req_if
   import pee_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             first;

   modport source (output valid, symbol, first, input ready);
   modport sink   (input valid, symbol, first, output ready);
endinterface

>>> sv/pee_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_rsp_if
// Result channel: stack top, depth and status per transaction.
// ----------------------------------------------------------------------------
interface pee_rsp_if
   import pee_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   top_value;
   logic        [DEPTH_W-1:0]  depth;
   logic        [STATUS_W-1:0] status;

   modport source (output valid, top_value, depth, status, input ready);
   modport sink   (input valid, top_value, depth, status, output ready);
endinterface

>>> sv/postfix_expression_evaluator_core.sv
`timescale 1ns / 1ps
// A digit, an ignored symbol or an error goes from decode straight to the result;
// an operator passes through fetch and execute, and waits there while the unit is busy.
// One symbol in flight: the next is taken only after the result is registered.
// Divide and power with a non-negative exponent run on the 32-step
// shared divide / square-and-multiply unit.
// Synchronous reset empties the stack (count to zero); stack RAM is not cleared.
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix evaluator top level: controller and datapath on valid/ready channels.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core
   import pee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pee_req_if.sink      req_chan,
   pee_rsp_if.source    rsp_chan
);

   cmd_type             cmd;
   stat_type            stat;
   logic                req_ready;
   logic                rsp_valid;
   logic [DATA_W-1:0]   rsp_top_value;
   logic [DEPTH_W-1:0]  rsp_depth;
   logic [STATUS_W-1:0] rsp_status;

   pee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pee_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_symbol    (req_chan.symbol),
      .req_first     (req_chan.first),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_valid),
      .rsp_top_value (rsp_top_value),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status)
   );

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.top_value = rsp_top_value;
   assign rsp_chan.depth     = rsp_depth;
   assign rsp_chan.status    = rsp_status;

endmodule

>>> sv/pee_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/pee_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_alu
// Iterative arithmetic unit: add/sub completed on start, one-step multiply,
// 32-step restoring divide and 32-step square-and-multiply power.
// ----------------------------------------------------------------------------
module pee_alu
   import pee_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  alu_op_type        op,
   input  logic [DATA_W-1:0] opnd_b,
   input  logic [DATA_W-1:0] opnd_a,
   output logic              busy,
   output logic [DATA_W-1:0] result
);

   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] aux_ff, aux_in;
   logic [DATA_W-1:0] shf_ff, shf_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              busy_ff, busy_in;
   logic              div_ff, div_in;
   logic              neg_ff, neg_in;

   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   rem_diff;
   logic [DATA_W-1:0] prod_acc;
   logic [DATA_W-1:0] prod_sq;
   logic [DATA_W-1:0] mag_b;
   logic [DATA_W-1:0] mag_a;
   logic [DATA_W-1:0] quot;

   assign mag_b    = opnd_b[DATA_W-1] ? (~opnd_b + DATA_W'(1)) : opnd_b;
   assign mag_a    = opnd_a[DATA_W-1] ? (~opnd_a + DATA_W'(1)) : opnd_a;
   assign rem_sh   = {acc_ff, shf_ff[DATA_W-1]};
   assign rem_diff = rem_sh - {1'b0, aux_ff};
   assign prod_acc = acc_ff * aux_ff;
   assign prod_sq  = aux_ff * aux_ff;

   always_comb begin
      acc_in   = acc_ff;
      aux_in   = aux_ff;
      shf_in   = shf_ff;
      steps_in = steps_ff;
      busy_in  = busy_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      if (start) begin
         div_in = 1'b0;
         case (op)
            OP_ADD: begin
               acc_in   = opnd_b + opnd_a;
               steps_in = '0;
               busy_in  = 1'b0;
            end
            OP_SUB: begin
               acc_in   = opnd_b - opnd_a;
               steps_in = '0;
               busy_in  = 1'b0;
            end
            OP_MUL: begin
               // one pass of the power step with exponent one
               acc_in   = opnd_b;
               aux_in   = opnd_a;
               shf_in   = DATA_W'(1);
               steps_in = STEP_W'(1);
               busy_in  = 1'b1;
            end
            OP_DIV: begin
               acc_in   = '0;
               aux_in   = mag_a;
               shf_in   = mag_b;
               neg_in   = opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
               div_in   = 1'b1;
               steps_in = STEP_W'(DATA_W);
               busy_in  = 1'b1;
            end
            OP_POW: begin
               if (opnd_a[DATA_W-1]) begin
                  // negative exponent gives zero
                  acc_in   = '0;
                  steps_in = '0;
                  busy_in  = 1'b0;
               end else begin
                  acc_in   = DATA_W'(1);
                  aux_in   = opnd_b;
                  shf_in   = opnd_a;
                  steps_in = STEP_W'(DATA_W);
                  busy_in  = 1'b1;
               end
            end
            default: begin
               acc_in   = '0;
               steps_in = '0;
               busy_in  = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!rem_diff[DATA_W]) begin
               acc_in = rem_diff[DATA_W-1:0];
               shf_in = {shf_ff[DATA_W-2:0], 1'b1};
            end else begin
               acc_in = rem_sh[DATA_W-1:0];
               shf_in = {shf_ff[DATA_W-2:0], 1'b0};
            end
         end else begin
            if (shf_ff[0]) begin
               acc_in = prod_acc;
            end
            aux_in = prod_sq;
            shf_in = {1'b0, shf_ff[DATA_W-1:1]};
         end
         steps_in = steps_ff - STEP_W'(1);
         busy_in  = (steps_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         steps_ff <= '0;
         div_ff   <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         steps_ff <= steps_in;
         div_ff   <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      aux_ff <= aux_in;
      shf_ff <= shf_in;
      neg_ff <= neg_in;
   end

   assign quot   = neg_ff ? (~shf_ff + DATA_W'(1)) : shf_ff;
   assign result = div_ff ? quot : acc_ff;
   assign busy   = busy_ff;

endmodule

>>> sv/pee_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_dp
// Datapath: symbol register, stack count, cached stack top, operand stack
// RAM, arithmetic unit and the result output register.
// ----------------------------------------------------------------------------
module pee_dp
   import pee_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic                req_first,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [DATA_W-1:0]   rsp_top_value,
   output logic [DEPTH_W-1:0]  rsp_depth,
   output logic [STATUS_W-1:0] rsp_status
);

   logic [SYM_W-1:0]    sym_ff, sym_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DATA_W-1:0]   top_ff, top_in;
   status_type          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_top_ff, rsp_top_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]    below_cnt;
   logic [DATA_W-1:0]   digit_val;
   alu_op_type          alu_op;
   logic                alu_busy;
   logic [DATA_W-1:0]   alu_result;
   logic [DATA_W-1:0]   ram_rdata;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [DATA_W-1:0]   ram_wr_data;
   logic [SYM_W-1:0]    digit_code;

   assign below_cnt  = count_ff - CNT_W'(2);
   assign digit_code = sym_ff - CH_ZERO;
   assign digit_val  = DATA_W'(digit_code);

   always_comb begin
      case (sym_ff)
         CH_PLUS:  alu_op = OP_ADD;
         CH_MINUS: alu_op = OP_SUB;
         CH_STAR:  alu_op = OP_MUL;
         CH_SLASH: alu_op = OP_DIV;
         default:  alu_op = OP_POW;
      endcase
   end

   always_comb begin
      stat.is_digit    = sym_ff inside {[CH_ZERO:CH_NINE]};
      stat.is_op       = sym_ff inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
      stat.stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
      stat.stack_short = (count_ff < CNT_W'(2));
      // divisor is the cached top entry
      stat.div_zero    = (alu_op == OP_DIV) && (top_ff == '0);
      stat.alu_busy    = alu_busy;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // push writes the new top slot, commit overwrites the lower operand
   assign ram_wr_en   = cmd.push || cmd.commit;
   assign ram_wr_addr = cmd.push ? count_ff[ADDR_W-1:0] : below_cnt[ADDR_W-1:0];
   assign ram_wr_data = cmd.push ? digit_val : alu_result;

   pee_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_below),
      .rd_addr (below_cnt[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   pee_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.alu_start),
      .op     (alu_op),
      .opnd_b (ram_rdata),
      .opnd_a (top_ff),
      .busy   (alu_busy),
      .result (alu_result)
   );

   always_comb begin
      sym_in        = sym_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.load) begin
         sym_in = req_symbol;
         if (req_first) begin
            count_in = '0;
         end
      end
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
         top_in   = digit_val;
      end
      if (cmd.commit) begin
         count_in = count_ff - CNT_W'(1);
         top_in   = alu_result;
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end

      if (cmd.respond) begin
         rsp_valid_in  = 1'b1;
         rsp_top_in    = (count_ff == '0) ? '0 : top_ff;
         rsp_depth_in  = DEPTH_W'(count_ff);
         rsp_status_in = status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      top_ff        <= top_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.stack_full)
      else $error("push on full stack");

   a_commit_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("commit did not pop one entry");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.alu_start |-> !alu_busy && !stat.stack_short)
      else $error("alu started while busy or short of operands");

   a_respond_room: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> stat.out_free)
      else $error("result overwrites a pending transaction");

endmodule

>>> sv/pee_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_ctrl
// Controller: sequences decode, stack access, arithmetic and result hand-off
// for one transaction at a time.
// ----------------------------------------------------------------------------
module pee_ctrl
   import pee_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_op && !stat.stack_short && !stat.div_zero) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_RESPOND;
            end
         end
         S_FETCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!stat.alu_busy) begin
               state_in = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.status = ST_OK;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_DECODE: begin
            cmd.set_status = 1'b1;
            if (stat.is_digit) begin
               if (stat.stack_full) begin
                  cmd.status = ST_OVERFLOW;
               end else begin
                  cmd.push   = 1'b1;
                  cmd.status = ST_OK;
               end
            end else if (stat.is_op) begin
               if (stat.stack_short) begin
                  cmd.status = ST_UNDERFLOW;
               end else if (stat.div_zero) begin
                  cmd.status = ST_DIVZERO;
               end else begin
                  cmd.rd_below = 1'b1;
                  cmd.status   = ST_OK;
               end
            end else begin
               cmd.status = ST_IGNORED;
            end
         end
         S_FETCH: begin
            cmd.alu_start = 1'b1;
         end
         S_EXEC: begin
            cmd.commit = !stat.alu_busy;
         end
         S_RESPOND: begin
            cmd.respond = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
